/* sv/vinkw_pkg.sv */
// -----------------------------------------------------------------------------
// Velocity ink width segmenter - shared definitions
// Widths, codes, the width shape table and the microcode program.
// -----------------------------------------------------------------------------
package vinkw_pkg;

    // Field widths
    localparam int CoordW   = 16;
    localparam int WidthW   = 12;
    localparam int SpeedW   = 16;
    localparam int RatioW   = 16;
    localparam int OpW      = 2;
    localparam int InDataW  = 48;   // pos_x, pos_y, speed
    localparam int InUserW  = OpW;
    localparam int OutDataW = 104;  // 4 coords, 2 widths, peak speed
    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 16;

    localparam logic [WidthW-1:0] WidthMax = {WidthW{1'b1}};

    // Shared multiplier
    localparam int MulW  = 16;
    localparam int ProdW = 2 * MulW;

    // Shape table
    localparam int TableDepth   = 256;
    localparam int TblLast      = TableDepth - 1;
    localparam int TblTwiceLast = 2 * TblLast;
    localparam int TblIdxW      = $clog2(TableDepth);

    // Index divider: (v*2L + thr) / (2*thr), run only while v < thr
    localparam int DivQW   = TblIdxW;
    localparam int DivNumW = SpeedW + $clog2(TblTwiceLast + 1);
    localparam int DivDenW = SpeedW + 1;
    localparam int DivCntW = $clog2(DivQW + 1);

    // Opcodes
    localparam logic [OpW-1:0] OP_DOWN  = 2'd0;
    localparam logic [OpW-1:0] OP_MOVE  = 2'd1;
    localparam logic [OpW-1:0] OP_CLEAR = 2'd2;

    // Register indexes
    localparam logic [CfgAddrW-1:0] CFG_STROKE   = 3'd0;
    localparam logic [CfgAddrW-1:0] CFG_MIN      = 3'd1;
    localparam logic [CfgAddrW-1:0] CFG_FADEIN   = 3'd2;
    localparam logic [CfgAddrW-1:0] CFG_FADEOUT  = 3'd3;
    localparam logic [CfgAddrW-1:0] CFG_THRESH   = 3'd4;
    localparam logic [CfgAddrW-1:0] CFG_CONSTANT = 3'd5;

    typedef struct packed {
        logic [WidthW-1:0] stroke;
        logic [WidthW-1:0] minw;
        logic [RatioW-1:0] fadein;
        logic [RatioW-1:0] fadeout;
        logic [SpeedW-1:0] thr;
        logic              cmode;
    } t_cfg;

    // Datapath micro-operations
    typedef enum logic [4:0] {
        U_IDLE, U_NOP, U_PEAK, U_DIV_GO, U_IDX_DIV, U_IDX_MAX, U_LOOKUP,
        U_CURVE, U_W_MIN, U_CLAMP_HI, U_CLAMP_LO, U_DIFF, U_D2_LD,
        U_D2_ADD, U_CMP, U_DOWN_SET, U_EMIT
    } t_uop;

    // Multiplier operand selection
    typedef enum logic [3:0] {
        M_NONE, M_V2L, M_DE, M_FIN, M_FOUT, M_SFOUT, M_DX, M_DY, M_BIG
    } t_mul;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NONE, C_ALWAYS, C_OP_DOWN, C_NOT_MOVE, C_THR_ZERO, C_V_GE_THR,
        C_DIV_BUSY, C_PREV_ZERO
    } t_cond;

    typedef logic [4:0] t_pc;

    typedef struct packed {
        t_uop  uop;
        t_mul  mul;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // Control to the datapath
    typedef struct packed {
        t_uop uop;
        t_mul mul;
        logic en;
    } t_ctl;

    // Status back to the sequencer
    typedef struct packed {
        logic op_down;
        logic not_move;
        logic thr_zero;
        logic v_ge_thr;
        logic div_busy;
        logic prev_zero;
        logic out_free;
    } t_sts;

    // Program labels
    localparam t_pc P_IDLE  = 5'd0;
    localparam t_pc P_PEAK  = 5'd1;
    localparam t_pc P_MOVE  = 5'd2;
    localparam t_pc P_THR   = 5'd3;
    localparam t_pc P_RANGE = 5'd4;
    localparam t_pc P_DIV   = 5'd5;
    localparam t_pc P_WAIT  = 5'd6;
    localparam t_pc P_IDX   = 5'd7;
    localparam t_pc P_CAP   = 5'd8;
    localparam t_pc P_LOOK  = 5'd9;
    localparam t_pc P_MDE   = 5'd10;
    localparam t_pc P_CURVE = 5'd11;
    localparam t_pc P_WMIN  = 5'd12;
    localparam t_pc P_FADE  = 5'd13;
    localparam t_pc P_HI    = 5'd14;
    localparam t_pc P_LO    = 5'd15;
    localparam t_pc P_DIST  = 5'd16;
    localparam t_pc P_SQX   = 5'd17;
    localparam t_pc P_SQY   = 5'd18;
    localparam t_pc P_SQB   = 5'd19;
    localparam t_pc P_CMP   = 5'd20;
    localparam t_pc P_DOWN  = 5'd21;
    localparam t_pc P_DSET  = 5'd22;
    localparam t_pc P_EMIT  = 5'd23;

    function automatic t_uword uw(input t_uop u, input t_mul m, input t_cond c,
                                  input t_pc t);
        t_uword w;
        w.uop    = u;
        w.mul    = m;
        w.cond   = c;
        w.target = t;
        return w;
    endfunction

    // Microcode ROM: a taken condition jumps, otherwise fall through
    function automatic t_uword micro_rom(input t_pc pc);
        t_uword w;
        unique case (pc)
            P_IDLE:  w = uw(U_IDLE,     M_NONE,  C_NONE,      P_IDLE);
            P_PEAK:  w = uw(U_PEAK,     M_NONE,  C_OP_DOWN,   P_DOWN);
            P_MOVE:  w = uw(U_NOP,      M_NONE,  C_NOT_MOVE,  P_EMIT);
            P_THR:   w = uw(U_NOP,      M_V2L,   C_THR_ZERO,  P_WMIN);
            P_RANGE: w = uw(U_NOP,      M_NONE,  C_V_GE_THR,  P_CAP);
            P_DIV:   w = uw(U_DIV_GO,   M_NONE,  C_NONE,      P_IDLE);
            P_WAIT:  w = uw(U_NOP,      M_NONE,  C_DIV_BUSY,  P_WAIT);
            P_IDX:   w = uw(U_IDX_DIV,  M_NONE,  C_ALWAYS,    P_LOOK);
            P_CAP:   w = uw(U_IDX_MAX,  M_NONE,  C_NONE,      P_IDLE);
            P_LOOK:  w = uw(U_LOOKUP,   M_NONE,  C_NONE,      P_IDLE);
            P_MDE:   w = uw(U_NOP,      M_DE,    C_NONE,      P_IDLE);
            P_CURVE: w = uw(U_CURVE,    M_NONE,  C_ALWAYS,    P_FADE);
            P_WMIN:  w = uw(U_W_MIN,    M_NONE,  C_NONE,      P_IDLE);
            P_FADE:  w = uw(U_NOP,      M_FIN,   C_PREV_ZERO, P_DIST);
            P_HI:    w = uw(U_CLAMP_HI, M_FOUT,  C_NONE,      P_IDLE);
            P_LO:    w = uw(U_CLAMP_LO, M_NONE,  C_NONE,      P_IDLE);
            P_DIST:  w = uw(U_DIFF,     M_NONE,  C_NONE,      P_IDLE);
            P_SQX:   w = uw(U_NOP,      M_DX,    C_NONE,      P_IDLE);
            P_SQY:   w = uw(U_D2_LD,    M_DY,    C_NONE,      P_IDLE);
            P_SQB:   w = uw(U_D2_ADD,   M_BIG,   C_NONE,      P_IDLE);
            P_CMP:   w = uw(U_CMP,      M_NONE,  C_ALWAYS,    P_EMIT);
            P_DOWN:  w = uw(U_NOP,      M_SFOUT, C_NONE,      P_IDLE);
            P_DSET:  w = uw(U_DOWN_SET, M_NONE,  C_NONE,      P_IDLE);
            P_EMIT:  w = uw(U_EMIT,     M_NONE,  C_ALWAYS,    P_IDLE);
            default: w = uw(U_NOP,      M_NONE,  C_ALWAYS,    P_IDLE);
        endcase
        return w;
    endfunction

    // Raised cosine shape table, built at elaboration
    localparam logic [63:0] Q30One = 64'd1073741824;
    localparam logic [63:0] PiQ30  = 64'd3373259426;

    typedef logic [WidthW-1:0] t_tbl [TableDepth];

    // sin(x) in Q30 for 0 <= x <= pi/2, odd terms up to x^13
    function automatic logic [63:0] sine_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        int          k;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (k = 1; k <= 6; k++) begin
            term = (term * x2) >> 30;
            unique case (k)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                default: term = term / 64'd156;
            endcase
            if (k[0])
                sum = sum - term;
            else
                sum = sum + term;
        end
        return sum;
    endfunction

    function automatic t_tbl build_shape();
        t_tbl        t;
        logic [63:0] x;
        logic [63:0] s;
        int          i;
        for (i = 0; i < TableDepth; i++) begin
            t[i] = '0;
            if (2 * i >= TblLast) begin
                x = (PiQ30 * 64'(2 * i - TblLast)) / 64'(TblTwiceLast);
                s = sine_q30(x);
                if (s > Q30One)
                    s = Q30One;
                t[i] = WidthW'((64'(WidthMax) * (Q30One - s) + Q30One) >> 31);
            end
        end
        // lower half mirrors the upper half about mid-scale
        for (i = 0; 2 * i < TblLast; i++)
            t[i] = WidthMax - t[TblLast - i];
        return t;
    endfunction

    localparam t_tbl ShapeTable = build_shape();

endpackage

/* sv/vinkw_div.sv */
// -----------------------------------------------------------------------------
// Velocity ink width segmenter - index divider
// Restoring divider, one quotient bit per cycle; quotient must fit DivQW bits.
// -----------------------------------------------------------------------------
module vinkw_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [vinkw_pkg::DivNumW-1:0] i_num,
    input  logic [vinkw_pkg::DivDenW-1:0] i_den,
    output logic                          o_busy,
    output logic [vinkw_pkg::DivQW-1:0]   o_quo
);
    import vinkw_pkg::*;

    logic [DivCntW-1:0] r_cnt;
    logic [DivDenW-1:0] r_rem;
    logic [DivDenW-1:0] r_den;
    logic [DivQW-1:0]   r_nlo;
    logic [DivQW-1:0]   r_quo;

    logic [DivDenW:0]   trial;
    logic               ge;

    assign trial = {r_rem, r_nlo[DivQW-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DivCntW'(DivQW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // top bits are below the divisor, so the quotient fits
            r_rem <= DivDenW'(i_num >> DivQW);
            r_nlo <= i_num[DivQW-1:0];
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? DivDenW'(trial - {1'b0, r_den}) : DivDenW'(trial);
            r_nlo <= r_nlo << 1;
            r_quo <= {r_quo[DivQW-2:0], ge};
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quo  = r_quo;

endmodule

/* sv/vinkw_seq.sv */
// -----------------------------------------------------------------------------
// Velocity ink width segmenter - microcode sequencer
// Step counter over the control ROM with conditional jumps and wait steps.
// -----------------------------------------------------------------------------
module vinkw_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  vinkw_pkg::t_sts i_sts,
    output vinkw_pkg::t_ctl o_ctl,
    output logic            o_in_ready
);
    import vinkw_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword word;
    logic   take;
    logic   hold;

    assign word = micro_rom(r_pc);

    always_comb begin
        unique case (word.cond)
            C_NONE:      take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_OP_DOWN:   take = i_sts.op_down;
            C_NOT_MOVE:  take = i_sts.not_move;
            C_THR_ZERO:  take = i_sts.thr_zero;
            C_V_GE_THR:  take = i_sts.v_ge_thr;
            C_DIV_BUSY:  take = i_sts.div_busy;
            C_PREV_ZERO: take = i_sts.prev_zero;
            default:     take = 1'b0;
        endcase
    end

    // idle waits for an item, emit waits for room in the output register
    assign hold = ((word.uop == U_IDLE) && !i_in_valid) ||
                  ((word.uop == U_EMIT) && !i_sts.out_free);

    always_comb begin
        priority if (hold) begin
            n_pc = r_pc;
        end else if (take) begin
            n_pc = word.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= P_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl.uop  = word.uop;
    assign o_ctl.mul  = word.mul;
    assign o_ctl.en   = !hold;
    assign o_in_ready = word.uop == U_IDLE;

endmodule

/* sv/vinkw_dp.sv */
// -----------------------------------------------------------------------------
// Velocity ink width segmenter - datapath
// Pen state, scratch registers, shared multiplier, divider and output register.
// -----------------------------------------------------------------------------
module vinkw_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  vinkw_pkg::t_cfg                i_cfg,
    input  vinkw_pkg::t_ctl                i_ctl,
    input  logic [vinkw_pkg::InDataW-1:0]  i_in_data,
    input  logic [vinkw_pkg::InUserW-1:0]  i_in_user,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [vinkw_pkg::OutDataW-1:0] o_out_data,
    output logic                           o_out_user,
    output vinkw_pkg::t_sts                o_sts
);
    import vinkw_pkg::*;

    // pen state
    logic [CoordW-1:0] r_prevx;
    logic [CoordW-1:0] r_prevy;
    logic [WidthW-1:0] r_prevw;
    logic [SpeedW-1:0] r_peak;

    // current item
    logic [OpW-1:0]    r_op;
    logic [CoordW-1:0] r_px;
    logic [CoordW-1:0] r_py;
    logic [SpeedW-1:0] r_v;

    // scratch
    logic [ProdW-1:0]   r_prod;
    logic [TblIdxW-1:0] r_idx;
    logic [WidthW-1:0]  r_e;
    logic [WidthW-1:0]  r_dw;
    logic               r_sgn;
    logic [WidthW-1:0]  r_w;
    logic [CoordW-1:0]  r_dx;
    logic [CoordW-1:0]  r_dy;
    logic [WidthW-1:0]  r_big;
    logic [ProdW:0]     r_d2;
    logic               r_seg;

    // output register
    logic                r_ovalid;
    logic                r_oseg;
    logic [CoordW-1:0]   r_osx;
    logic [CoordW-1:0]   r_osy;
    logic [CoordW-1:0]   r_oex;
    logic [CoordW-1:0]   r_oey;
    logic [WidthW-1:0]   r_osw;
    logic [WidthW-1:0]   r_oew;
    logic [SpeedW-1:0]   r_opk;

    logic              latch;
    logic              emit;
    logic              out_free;
    logic [MulW-1:0]   mul_a;
    logic [MulW-1:0]   mul_b;
    logic              div_busy;
    logic [DivQW-1:0]  div_quo;
    logic [DivNumW-1:0] div_num;
    logic [DivDenW-1:0] div_den;

    logic [23:0]        cx;
    logic [WidthW-1:0]  cq0;
    logic [WidthW:0]    cr;
    logic [WidthW-1:0]  cq;
    logic [WidthW-1:0]  curve_w;
    logic [WidthW-1:0]  lim;
    logic [CoordW:0]    dxs;
    logic [CoordW:0]    dys;
    logic [CoordW:0]    dxa;
    logic [CoordW:0]    dya;

    function automatic logic [WidthW-1:0] scale_sat(input logic [ProdW-1:0] p);
        logic [ProdW-1:0] r;
        r = (p + ProdW'(2048)) >> 12;
        return (r > ProdW'(WidthMax)) ? WidthMax : r[WidthW-1:0];
    endfunction

    assign latch    = i_ctl.en && (i_ctl.uop == U_IDLE);
    assign emit     = i_ctl.en && (i_ctl.uop == U_EMIT);
    assign out_free = !r_ovalid || i_out_ready;

    // shared multiplier operands
    always_comb begin
        unique case (i_ctl.mul)
            M_V2L:   begin mul_a = r_v;            mul_b = MulW'(TblTwiceLast); end
            M_DE:    begin mul_a = MulW'(r_dw);    mul_b = MulW'(r_e);          end
            M_FIN:   begin mul_a = MulW'(r_prevw); mul_b = i_cfg.fadein;        end
            M_FOUT:  begin mul_a = MulW'(r_prevw); mul_b = i_cfg.fadeout;       end
            M_SFOUT: begin mul_a = MulW'(i_cfg.stroke); mul_b = i_cfg.fadeout;  end
            M_DX:    begin mul_a = r_dx;           mul_b = r_dx;                end
            M_DY:    begin mul_a = r_dy;           mul_b = r_dy;                end
            M_BIG:   begin mul_a = MulW'(r_big);   mul_b = MulW'(r_big);        end
            default: begin mul_a = '0;             mul_b = '0;                  end
        endcase
    end

    // index division
    assign div_num = DivNumW'(r_prod) + DivNumW'(i_cfg.thr);
    assign div_den = {i_cfg.thr, 1'b0};

    vinkw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.en && (i_ctl.uop == U_DIV_GO)),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    // curve: (dw*e + 2047) / 4095, using 4096 = 4095 + 1
    assign cx      = r_prod[23:0] + 24'd2047;
    assign cq0     = cx[23:12];
    assign cr      = {1'b0, cx[11:0]} + {1'b0, cq0};
    assign cq      = cq0 + WidthW'(cr >= {1'b0, WidthMax});
    assign curve_w = r_sgn ? (i_cfg.minw - cq) : (i_cfg.minw + cq);
    assign lim     = scale_sat(r_prod);

    // signed deltas, magnitude fits 16 bits
    assign dxs = {r_px[CoordW-1], r_px} - {r_prevx[CoordW-1], r_prevx};
    assign dys = {r_py[CoordW-1], r_py} - {r_prevy[CoordW-1], r_prevy};
    assign dxa = dxs[CoordW] ? -dxs : dxs;
    assign dya = dys[CoordW] ? -dys : dys;

    // scratch and item registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul != M_NONE)
            r_prod <= ProdW'(mul_a) * ProdW'(mul_b);
        if (latch) begin
            r_px  <= i_in_data[15:0];
            r_py  <= i_in_data[31:16];
            r_v   <= i_in_data[47:32];
            r_op  <= i_in_user;
            r_seg <= 1'b0;
        end
        if (i_ctl.en) begin
            unique case (i_ctl.uop)
                U_IDX_DIV: r_idx <= (div_quo > DivQW'(TblLast)) ?
                                    TblIdxW'(TblLast) : div_quo;
                U_IDX_MAX: r_idx <= TblIdxW'(TblLast);
                U_LOOKUP: begin
                    r_e   <= ShapeTable[r_idx];
                    r_sgn <= i_cfg.stroke < i_cfg.minw;
                    r_dw  <= (i_cfg.stroke < i_cfg.minw) ?
                             (i_cfg.minw - i_cfg.stroke) : (i_cfg.stroke - i_cfg.minw);
                end
                U_CURVE: r_w <= curve_w;
                U_W_MIN: r_w <= i_cfg.minw;
                U_CLAMP_HI: begin
                    if ((i_cfg.fadein != '0) && (r_w > lim))
                        r_w <= lim;
                end
                U_CLAMP_LO: begin
                    if ((i_cfg.fadeout != '0) && (r_w < lim))
                        r_w <= lim;
                end
                U_DIFF: begin
                    r_dx  <= dxa[CoordW-1:0];
                    r_dy  <= dya[CoordW-1:0];
                    r_big <= (r_w > r_prevw) ? r_w : r_prevw;
                end
                U_D2_LD:  r_d2  <= (ProdW+1)'(r_prod);
                U_D2_ADD: r_d2  <= r_d2 + (ProdW+1)'(r_prod);
                U_CMP:    r_seg <= (ProdW+3)'(r_prod[23:0]) <= {r_d2, 2'b00};
                default: ;
            endcase
        end
    end

    // pen state and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prevx  <= '0;
            r_prevy  <= '0;
            r_prevw  <= '0;
            r_peak   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_ctl.en && (i_ctl.uop == U_PEAK)) begin
                priority if (r_op == OP_CLEAR) begin
                    r_peak <= '0;
                end else if (((r_op == OP_DOWN) || (r_op == OP_MOVE)) && (r_v > r_peak)) begin
                    r_peak <= r_v;
                end
            end
            if (i_ctl.en && (i_ctl.uop == U_DOWN_SET)) begin
                r_prevx <= r_px;
                r_prevy <= r_py;
                r_prevw <= (i_cfg.fadeout != '0) ? lim : i_cfg.minw;
            end
            if (emit && r_seg) begin
                r_prevx <= r_px;
                r_prevy <= r_py;
                r_prevw <= r_w;
            end
            priority if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_oseg <= r_seg;
            r_opk  <= r_peak;
            r_osx  <= r_seg ? r_px : '0;
            r_osy  <= r_seg ? r_py : '0;
            r_oex  <= r_seg ? r_prevx : '0;
            r_oey  <= r_seg ? r_prevy : '0;
            r_osw  <= !r_seg ? '0 : (i_cfg.cmode ? i_cfg.stroke : r_w);
            r_oew  <= !r_seg ? '0 : (i_cfg.cmode ? i_cfg.stroke : r_prevw);
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_user  = r_oseg;
    assign o_out_data  = {r_opk, r_oew, r_osw, r_oey, r_oex, r_osy, r_osx};

    assign o_sts.op_down   = r_op == OP_DOWN;
    assign o_sts.not_move  = r_op != OP_MOVE;
    assign o_sts.thr_zero  = i_cfg.thr == '0;
    assign o_sts.v_ge_thr  = r_v >= i_cfg.thr;
    assign o_sts.div_busy  = div_busy;
    assign o_sts.prev_zero = r_prevw == '0;
    assign o_sts.out_free  = out_free;

endmodule

/* sv/velocity_ink_width_segmenter.sv */
// -----------------------------------------------------------------------------
// Velocity ink width segmenter - top level
// Pen events in, speed-shaped line segments out; microcoded datapath.
// -----------------------------------------------------------------------------
// Only one item is in flight at a time. A pen move holds the block until its
// result reaches the output register. Most of that time goes to two shared
// units. The first is the bit-serial index divider: one quotient bit per cycle,
// with its own wait step in the program. The second is the single shared
// 16x16 multiplier. The microcode uses it once per step, for the index product,
// the curve product, the two fade limits, the three squares of the distance
// test and the fade-out limit of a pen down. Shorter paths:
//  - a move whose speed reaches the threshold skips the divider;
//  - a move with a zero threshold also skips the curve;
//  - when no width is stored yet, the two fade steps drop out as well;
//  - a pen down is shorter still, and a clear or an unused opcode shortest.
// The result sits in an output register, so the next item is taken while it
// waits. The program stalls on its emit step only when that register is still
// full. Every accepted item gives exactly one result, with segment_valid low
// when nothing is drawn. Configuration is a plain write port and must be
// written while idle.
// -----------------------------------------------------------------------------
module velocity_ink_width_segmenter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [vinkw_pkg::CfgAddrW-1:0]      i_cfg_addr,
    input  logic [vinkw_pkg::CfgDataW-1:0]      i_cfg_data,
    // pen events
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [vinkw_pkg::InDataW-1:0]       s_axis_tdata,   // pos_x, pos_y, speed
    input  logic [vinkw_pkg::InUserW-1:0]       s_axis_tuser,   // opcode
    // segments
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [vinkw_pkg::OutDataW-1:0]      m_axis_tdata,   // start_x, start_y, end_x,
                                                                // end_y, start_width,
                                                                // end_width, peak_speed
    output logic                                m_axis_tuser    // segment_valid
);
    import vinkw_pkg::*;

    t_cfg r_cfg;
    t_ctl ctl;
    t_sts sts;

    // configuration registers; writes to unused indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stroke  <= 12'd48;
            r_cfg.minw    <= 12'd16;
            r_cfg.fadein  <= '0;
            r_cfg.fadeout <= '0;
            r_cfg.thr     <= 16'd1024;
            r_cfg.cmode   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_STROKE:   r_cfg.stroke  <= i_cfg_data[WidthW-1:0];
                CFG_MIN:      r_cfg.minw    <= i_cfg_data[WidthW-1:0];
                CFG_FADEIN:   r_cfg.fadein  <= i_cfg_data;
                CFG_FADEOUT:  r_cfg.fadeout <= i_cfg_data;
                CFG_THRESH:   r_cfg.thr     <= i_cfg_data;
                CFG_CONSTANT: r_cfg.cmode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // control program
    vinkw_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (sts),
        .o_ctl      (ctl),
        .o_in_ready (s_axis_tready)
    );

    // datapath, pen state and output register
    vinkw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_ctl       (ctl),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .o_sts       (sts)
    );

endmodule

/* sv/vinkw_chk.sv */
// -----------------------------------------------------------------------------
// Velocity ink width segmenter - port checker
// Concurrent checks on the top-level ports, bound to the top level.
// -----------------------------------------------------------------------------
module vinkw_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [vinkw_pkg::OutDataW-1:0]      m_axis_tdata,
    input logic                                m_axis_tuser
);
    import vinkw_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // one item at a time: ready drops after an item is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while busy");

    // no segment means no geometry
    a_no_seg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[87:0] == '0)
        else $error("geometry on a result without segment");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind velocity_ink_width_segmenter vinkw_chk u_chk (.*);

/* tb/tb_top.sv */
// -----------------------------------------------------------------------------
// Velocity ink width segmenter - testbench
// Drives pen events into the segmenter and checks every segment item that
// comes back against an in-bench predictor of the width curve, the fade limits,
// the draw test and the peak speed tracker. A short directed table comes first,
// then phases of random strokes under changing register settings. Both stream
// sides idle at random.
// -----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vinkw_pkg::*;

    typedef longint unsigned t_u64;

    // The spare opcode does nothing in the block but still returns an item
    localparam logic [OpW-1:0] OP_SPARE = 2'd3;

    localparam int   RunLimit  = 300000;  // cycles, several times the slowest run
    localparam int   PhaseCnt  = 12;
    localparam int   PhaseLen  = 36;      // minimum input items per random phase
    localparam t_u64 Q30Unit   = 64'd1073741824;
    localparam t_u64 PiFixed   = 64'd3373259426;

    // One segment item as the block reports it
    typedef struct packed {
        logic              drawn;
        logic [CoordW-1:0] sx;
        logic [CoordW-1:0] sy;
        logic [CoordW-1:0] ex;
        logic [CoordW-1:0] ey;
        logic [WidthW-1:0] sw;
        logic [WidthW-1:0] ew;
        logic [SpeedW-1:0] peak;
    } t_segment;

    // One row of the directed table: a register write or a pen event
    typedef struct {
        bit                  is_cfg;
        logic [CfgAddrW-1:0] addr;
        logic [CfgDataW-1:0] val;
        logic [OpW-1:0]      op;
        logic [CoordW-1:0]   x;
        logic [CoordW-1:0]   y;
        logic [SpeedW-1:0]   v;
        bit                  fixed;   // expected item typed in below
        t_segment            want;
    } t_stim_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CfgAddrW-1:0]  i_cfg_addr;
    logic [CfgDataW-1:0]  i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [InDataW-1:0]   s_axis_tdata;    // pos_x, pos_y, speed
    logic [InUserW-1:0]   s_axis_tuser;    // opcode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OutDataW-1:0]  m_axis_tdata;    // start_x, start_y, end_x, end_y,
                                           // start_width, end_width, peak_speed
    logic                 m_axis_tuser;    // segment_valid

    velocity_ink_width_segmenter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // -------------------------------------------------------------------------
    // Predictor state: register copies, pen state and the shape curve
    // -------------------------------------------------------------------------
    logic [WidthW-1:0] ink_stroke;
    logic [WidthW-1:0] ink_min;
    logic [RatioW-1:0] ink_fadein;
    logic [RatioW-1:0] ink_fadeout;
    logic [SpeedW-1:0] ink_thresh;
    logic              ink_const;

    logic [CoordW-1:0] pen_x;
    logic [CoordW-1:0] pen_y;
    logic [WidthW-1:0] pen_w;
    logic [SpeedW-1:0] peak_hold;

    logic [WidthW-1:0] shape_lut [TableDepth];

    t_segment  pending_segments [$];
    t_stim_row rows [$];
    int        faults;
    bit        calm;       // phase with no idling on either side

    // Raised cosine, 4095 at rest down to 0 at the threshold. Upper half from a
    // fixed-point sine series, lower half mirrored about mid-scale.
    function automatic void build_shape_lut();
        t_u64 x;
        t_u64 x2;
        t_u64 term;
        t_u64 sum;
        int   i;
        int   k;
        for (i = 0; i < TableDepth; i++) begin
            shape_lut[i] = '0;
            if (2 * i >= TblLast) begin
                x    = (PiFixed * t_u64'(2 * i - TblLast)) / t_u64'(2 * TblLast);
                x2   = (x * x) >> 30;
                term = x;
                sum  = x;
                for (k = 1; k <= 6; k++) begin
                    term = ((term * x2) >> 30) / t_u64'((2 * k) * (2 * k + 1));
                    if (k % 2 == 1)
                        sum = sum - term;
                    else
                        sum = sum + term;
                end
                if (sum > Q30Unit)
                    sum = Q30Unit;
                shape_lut[i] = WidthW'((t_u64'(4095) * (Q30Unit - sum) + Q30Unit) >> 31);
            end
        end
        for (i = 0; 2 * i < TblLast; i++)
            shape_lut[i] = 12'd4095 - shape_lut[TblLast - i];
    endfunction

    // width * Q4.12 ratio, rounded half up, saturated to the width range
    function automatic logic [WidthW-1:0] ratio_scale(input t_u64 w, input t_u64 ratio);
        t_u64 r;
        r = (w * ratio + 2048) >> 12;
        return (r > 4095) ? WidthMax : WidthW'(r);
    endfunction

    // Width for a move at speed v, fade limits included
    function automatic logic [WidthW-1:0] speed_width(input logic [SpeedW-1:0] v);
        t_u64 idx;
        t_u64 e;
        t_u64 w;
        t_u64 s;
        t_u64 m;
        t_u64 lim;
        s = ink_stroke;
        m = ink_min;
        if (ink_thresh == 0) begin
            w = m;
        end else begin
            idx = (t_u64'(v) * t_u64'(TblLast) * 2 + t_u64'(ink_thresh))
                  / (2 * t_u64'(ink_thresh));
            if (idx > TblLast)
                idx = TblLast;
            e = shape_lut[idx];
            // min above stroke: the curve runs the other way
            if (s >= m)
                w = m + ((s - m) * e + 2047) / 4095;
            else
                w = m - ((m - s) * e + 2047) / 4095;
        end
        // no fade limits until a width has been stored
        if (pen_w != 0) begin
            if (ink_fadein != 0) begin
                lim = ratio_scale(pen_w, ink_fadein);
                if (w > lim)
                    w = lim;
            end
            if (ink_fadeout != 0) begin
                lim = ratio_scale(pen_w, ink_fadeout);
                if (w < lim)
                    w = lim;
            end
        end
        return WidthW'(w);
    endfunction

    // Applies one pen event to the pen state and returns the item it causes
    function automatic t_segment advance_pen(input logic [OpW-1:0] op,
                                             input logic [CoordW-1:0] px, py,
                                             input logic [SpeedW-1:0] v);
        t_segment          r;
        logic [WidthW-1:0] w;
        logic [WidthW-1:0] big;
        longint            dx;
        longint            dy;
        longint            d2;
        r = '0;
        case (op)
            OP_DOWN: begin
                if (v > peak_hold)
                    peak_hold = v;
                pen_x = px;
                pen_y = py;
                pen_w = (ink_fadeout != 0) ? ratio_scale(ink_stroke, ink_fadeout) : ink_min;
            end
            OP_MOVE: begin
                if (v > peak_hold)
                    peak_hold = v;
                w   = speed_width(v);
                big = (w > pen_w) ? w : pen_w;
                dx  = longint'($signed(px)) - longint'($signed(pen_x));
                dy  = longint'($signed(py)) - longint'($signed(pen_y));
                d2  = dx * dx + dy * dy;
                // half the larger width must fit in the distance, as squares
                if (longint'(big) * longint'(big) <= 4 * d2) begin
                    r.drawn = 1'b1;
                    r.sx    = px;
                    r.sy    = py;
                    r.ex    = pen_x;
                    r.ey    = pen_y;
                    r.sw    = ink_const ? ink_stroke : w;
                    r.ew    = ink_const ? ink_stroke : pen_w;
                    pen_x   = px;
                    pen_y   = py;
                    pen_w   = w;
                end
            end
            OP_CLEAR: peak_hold = '0;
            default: ;
        endcase
        r.peak = peak_hold;
        return r;
    endfunction

    function automatic t_segment no_segment(input logic [SpeedW-1:0] peak);
        t_segment r;
        r      = '0;
        r.peak = peak;
        return r;
    endfunction

    function automatic string describe(input t_segment s);
        return $sformatf("drawn %0d start (%h,%h) end (%h,%h) widths %0d/%0d peak %0d",
                         s.drawn, s.sx, s.sy, s.ex, s.ey, s.sw, s.ew, s.peak);
    endfunction

    // -------------------------------------------------------------------------
    // Directed table entry points
    // -------------------------------------------------------------------------
    function automatic void add_cfg(input logic [CfgAddrW-1:0] addr,
                                    input logic [CfgDataW-1:0] val);
        t_stim_row r;
        r        = '{default: '0};
        r.is_cfg = 1'b1;
        r.addr   = addr;
        r.val    = val;
        rows.push_back(r);
    endfunction

    function automatic void add_event(input logic [OpW-1:0] op,
                                      input logic [CoordW-1:0] x, y,
                                      input logic [SpeedW-1:0] v,
                                      input bit fixed, input t_segment want);
        t_stim_row r;
        r       = '{default: '0};
        r.op    = op;
        r.x     = x;
        r.y     = y;
        r.v     = v;
        r.fixed = fixed;
        r.want  = want;
        rows.push_back(r);
    endfunction

    // -------------------------------------------------------------------------
    // Random draws
    // -------------------------------------------------------------------------
    function automatic int idle_cycles();
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    // speeds cluster around the threshold, with rest, full range and overshoot
    function automatic logic [SpeedW-1:0] draw_speed();
        t_u64 t;
        t_u64 s;
        t = ink_thresh;
        case ($urandom_range(0, 4))
            0:       s = $urandom_range(0, 65535);
            1:       s = 0;
            2:       s = $urandom_range(0, int'(t));
            3:       s = (t + $urandom_range(0, 4) > 2) ? t + $urandom_range(0, 4) - 2 : 0;
            default: s = $urandom_range(0, int'(2 * t));
        endcase
        return (s > 65535) ? 16'hFFFF : SpeedW'(s);
    endfunction

    // pen step on one axis, scaled to the stroke so that some are too short
    function automatic logic [CoordW-1:0] draw_step();
        int span;
        int mag;
        case ($urandom_range(0, 3))
            0:       span = int'(ink_stroke) / 4 + 2;
            3:       span = 4095;
            default: span = int'(ink_stroke) + 16;
        endcase
        mag = $urandom_range(0, span);
        return CoordW'($urandom_range(0, 1) ? -mag : mag);
    endfunction

    // -------------------------------------------------------------------------
    // Bus tasks: drive at the falling edge, sample at the rising edge
    // -------------------------------------------------------------------------
    task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_addr = addr;
        i_cfg_data = val;
        case (addr)
            CFG_STROKE:   ink_stroke  = val[WidthW-1:0];
            CFG_MIN:      ink_min     = val[WidthW-1:0];
            CFG_FADEIN:   ink_fadein  = val;
            CFG_FADEOUT:  ink_fadeout = val;
            CFG_THRESH:   ink_thresh  = val;
            CFG_CONSTANT: ink_const   = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Returns at the rising edge that accepted the item; valid stays high
    // until the next call or until the bus is released.
    task automatic push_item(input logic [OpW-1:0] op, input logic [CoordW-1:0] x, y,
                             input logic [SpeedW-1:0] v, input bit fixed,
                             input t_segment want);
        int       gap;
        t_segment exp_seg;
        gap = idle_cycles();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {v, y, x};
        s_axis_tuser  = op;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        exp_seg = advance_pen(op, x, y, v);
        pending_segments.push_back(fixed ? want : exp_seg);
    endtask

    // Drop valid and wait for every outstanding item; every event returns
    // exactly one item, so an empty queue means the block is idle.
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_segments.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // -------------------------------------------------------------------------
    // Clock and run limit
    // -------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < RunLimit) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // -------------------------------------------------------------------------
    // Segment side: random back-pressure, then compare with the oldest entry
    // -------------------------------------------------------------------------
    initial begin
        int       hold;
        t_segment got;
        t_segment want;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            hold = idle_cycles();
            @(negedge i_clk);
            if (hold > 0) begin
                m_axis_tready = 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got.drawn = m_axis_tuser;
            got.sx    = m_axis_tdata[15:0];
            got.sy    = m_axis_tdata[31:16];
            got.ex    = m_axis_tdata[47:32];
            got.ey    = m_axis_tdata[63:48];
            got.sw    = m_axis_tdata[75:64];
            got.ew    = m_axis_tdata[87:76];
            got.peak  = m_axis_tdata[103:88];
            if (pending_segments.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected segment item: %s", describe(got));
            end else begin
                want = pending_segments.pop_front();
                if (got.drawn !== want.drawn || got.sx !== want.sx || got.sy !== want.sy ||
                    got.ex !== want.ex || got.ey !== want.ey || got.sw !== want.sw ||
                    got.ew !== want.ew || got.peak !== want.peak) begin
                    faults++;
                    if (faults <= 10) begin
                        $display("segment mismatch at %0t", $realtime);
                        $display("  expected %s", describe(want));
                        $display("  actual   %s", describe(got));
                    end
                end
            end
        end
    end

    // -------------------------------------------------------------------------
    // Stimulus
    // -------------------------------------------------------------------------
    initial begin
        int                phase;
        int                count;
        int                moves;
        logic [CoordW-1:0] px;
        logic [CoordW-1:0] py;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        faults        = 0;
        calm          = 1'b0;

        // register reset values and a cleared pen
        ink_stroke  = 12'd48;
        ink_min     = 12'd16;
        ink_fadein  = '0;
        ink_fadeout = '0;
        ink_thresh  = 16'd1024;
        ink_const   = 1'b0;
        pen_x       = '0;
        pen_y       = '0;
        pen_w       = '0;
        peak_hold   = '0;
        build_shape_lut();

        // --- directed table ---
        // straight after reset: spare opcode leaves everything alone
        add_event(OP_SPARE, 16'h7FFF, 16'h8000, 16'hFFFF, 1, no_segment(16'd0));
        // moves with no pen down: the reset point, first too short, then drawn
        add_event(OP_MOVE, 16'h0000, 16'h0000, 16'd0, 0, '0);
        add_event(OP_MOVE, 16'd100, 16'h0000, 16'd0, 0, '0);
        add_event(OP_DOWN, 16'h8000, 16'h8000, 16'hFFFF, 1, no_segment(16'hFFFF));
        add_event(OP_MOVE, 16'h7FFF, 16'h7FFF, 16'hFFFF, 0, '0);
        add_event(OP_CLEAR, 16'h0000, 16'h0000, 16'hFFFF, 1, no_segment(16'd0));
        // speeds either side of the threshold
        add_event(OP_MOVE, 16'h7FFF, 16'h7FC0, 16'd512, 0, '0);
        add_event(OP_MOVE, 16'h7FFF, 16'h7F80, 16'd1023, 0, '0);
        add_event(OP_MOVE, 16'h7FFF, 16'h7F40, 16'd1024, 0, '0);
        add_event(OP_MOVE, 16'h7FFF, 16'h7F00, 16'd1025, 0, '0);
        // zero threshold gives the minimum width
        add_cfg(CFG_THRESH, 16'd0);
        add_event(OP_MOVE, 16'h7FFF, 16'h7E00, 16'd0, 0, '0);
        // minimum above stroke: curve runs upwards
        add_cfg(CFG_STROKE, 16'd10);
        add_cfg(CFG_MIN, 16'd4000);
        add_cfg(CFG_THRESH, 16'hFFFF);
        add_event(OP_DOWN, 16'h0000, 16'h0000, 16'd0, 0, '0);
        add_event(OP_MOVE, 16'h1000, 16'h0000, 16'd0, 0, '0);
        add_event(OP_MOVE, 16'h2000, 16'h0000, 16'h8000, 0, '0);
        add_event(OP_MOVE, 16'h3000, 16'h0000, 16'hFFFF, 0, '0);
        // fade limits: growth at most 2.0, shrink at least 0.5
        add_cfg(CFG_STROKE, 16'd400);
        add_cfg(CFG_MIN, 16'd40);
        add_cfg(CFG_FADEIN, 16'h2000);
        add_cfg(CFG_FADEOUT, 16'h0800);
        add_cfg(CFG_THRESH, 16'd1000);
        add_event(OP_DOWN, 16'h0000, 16'h0000, 16'd0, 0, '0);
        add_event(OP_MOVE, 16'h0100, 16'h0000, 16'd0, 0, '0);
        add_event(OP_MOVE, 16'h0200, 16'h0000, 16'd2000, 0, '0);
        add_event(OP_MOVE, 16'h0200, 16'h0001, 16'd0, 0, '0);   // too short
        // saturating ratios and constant width
        add_cfg(CFG_STROKE, 16'd4095);
        add_cfg(CFG_MIN, 16'd0);
        add_cfg(CFG_FADEIN, 16'hFFFF);
        add_cfg(CFG_FADEOUT, 16'hFFFF);
        add_cfg(CFG_CONSTANT, 16'd1);
        add_event(OP_DOWN, 16'hFFFF, 16'hFFFF, 16'd0, 0, '0);
        add_event(OP_MOVE, 16'h7FFF, 16'h7FFF, 16'd0, 0, '0);
        // zero widths: a move onto the same point still draws
        add_cfg(CFG_STROKE, 16'd0);
        add_cfg(CFG_FADEIN, 16'd0);
        add_cfg(CFG_FADEOUT, 16'd0);
        add_cfg(CFG_CONSTANT, 16'd0);
        add_event(OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'h1234, 1, no_segment(16'd0));
        add_event(OP_DOWN, 16'd5, 16'd5, 16'd0, 1, no_segment(16'd0));
        add_event(OP_MOVE, 16'd5, 16'd5, 16'd0, 1,
                  '{1'b1, 16'd5, 16'd5, 16'd5, 16'd5, 12'd0, 12'd0, 16'd0});
        add_event(OP_SPARE, 16'h0000, 16'h0000, 16'h0000, 1, no_segment(16'd0));

        // hold reset, then release it at a falling edge
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                wait_idle();
                write_reg(rows[i].addr, rows[i].val);
            end else begin
                push_item(rows[i].op, rows[i].x, rows[i].y, rows[i].v,
                          rows[i].fixed, rows[i].want);
            end
        end

        // --- random phases: mostly pen down then a run of moves ---
        for (phase = 0; phase < PhaseCnt; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    write_reg(CFG_STROKE, 16'hFFFF);
                    write_reg(CFG_MIN, 16'd0);
                    write_reg(CFG_FADEIN, 16'hFFFF);
                    write_reg(CFG_FADEOUT, 16'hFFFF);
                    write_reg(CFG_THRESH, 16'hFFFF);
                    write_reg(CFG_CONSTANT, 16'hFFFF);
                end
                4: begin
                    write_reg(CFG_STROKE, 16'd0);
                    write_reg(CFG_MIN, 16'd4095);
                    write_reg(CFG_FADEIN, 16'd1);
                    write_reg(CFG_FADEOUT, 16'd1);
                    write_reg(CFG_THRESH, 16'd1);
                    write_reg(CFG_CONSTANT, 16'd0);
                end
                8: begin
                    write_reg(CFG_STROKE, 16'd0);
                    write_reg(CFG_MIN, 16'd0);
                    write_reg(CFG_FADEIN, 16'd0);
                    write_reg(CFG_FADEOUT, 16'd0);
                    write_reg(CFG_THRESH, 16'd0);
                    write_reg(CFG_CONSTANT, 16'd0);
                end
                default: begin
                    // small widths half of the time so that strokes draw often
                    write_reg(CFG_STROKE, $urandom_range(0, 1) ? 16'($urandom_range(0, 255))
                                                               : 16'($urandom_range(0, 65535)));
                    write_reg(CFG_MIN, $urandom_range(0, 1) ? 16'($urandom_range(0, 64))
                                                            : 16'($urandom_range(0, 65535)));
                    case ($urandom_range(0, 2))
                        0:       write_reg(CFG_FADEIN, 16'd0);
                        1:       write_reg(CFG_FADEIN, 16'($urandom_range(4096, 12288)));
                        default: write_reg(CFG_FADEIN, 16'($urandom_range(0, 65535)));
                    endcase
                    case ($urandom_range(0, 2))
                        0:       write_reg(CFG_FADEOUT, 16'd0);
                        1:       write_reg(CFG_FADEOUT, 16'($urandom_range(1024, 4096)));
                        default: write_reg(CFG_FADEOUT, 16'($urandom_range(0, 65535)));
                    endcase
                    case ($urandom_range(0, 3))
                        0:       write_reg(CFG_THRESH, 16'd0);
                        1:       write_reg(CFG_THRESH, 16'hFFFF);
                        2:       write_reg(CFG_THRESH, 16'($urandom_range(1, 4000)));
                        default: write_reg(CFG_THRESH, 16'($urandom_range(0, 65535)));
                    endcase
                    write_reg(CFG_CONSTANT, 16'($urandom_range(0, 1)));
                end
            endcase
            calm  = (phase % 3 == 1);
            count = 0;
            while (count < PhaseLen) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise: lone events at arbitrary positions and speeds
                    case ($urandom_range(0, 3))
                        0: push_item(OP_CLEAR, 16'($urandom), 16'($urandom),
                                     16'($urandom), 0, '0);
                        1: push_item(OP_SPARE, 16'($urandom), 16'($urandom),
                                     16'($urandom), 0, '0);
                        2: push_item(OP_MOVE, 16'($urandom), 16'($urandom),
                                     draw_speed(), 0, '0);
                        default: push_item(OP_DOWN, 16'($urandom), 16'($urandom),
                                           draw_speed(), 0, '0);
                    endcase
                    count++;
                end else begin
                    px = 16'($urandom);
                    py = 16'($urandom);
                    push_item(OP_DOWN, px, py, draw_speed(), 0, '0);
                    moves = $urandom_range(1, 10);
                    repeat (moves) begin
                        px = px + draw_step();
                        py = py + draw_step();
                        push_item(OP_MOVE, px, py, draw_speed(), 0, '0);
                    end
                    count += moves + 1;
                end
            end
        end

        // drain, then give any stray item time to show up
        wait_idle();
        repeat (60) @(posedge i_clk);
        if (faults == 0 && pending_segments.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
